// ===== rtl/spor_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spor_pkg
// Shared types and constants of the slot pool with oldest-slot recycling.
// ----------------------------------------------------------------------------
package spor_pkg;

   localparam logic       OP_ALLOC   = 1'b0;
   localparam logic       OP_RELEASE = 1'b1;

   localparam int         CSR_WIDTH  = 5;
   localparam int         SLOT_WIDTH = 4;
   localparam logic [4:0] CSR_RESET  = 5'd16;

   typedef struct packed {
      logic                  opcode;
      logic [SLOT_WIDTH-1:0] slot_number;
   } req_type;

   typedef struct packed {
      logic                  ok;
      logic [SLOT_WIDTH-1:0] granted_slot;
      logic                  recycled;
   } rsp_type;

   typedef struct packed {
      logic    done;
      rsp_type rsp;
   } seq_out_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_OLD_RD,
      ST_OLD_WAIT,
      ST_REL_CHK,
      ST_FIND_RD,
      ST_FIND_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/spor_list_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spor_list_ram
// Allocation-order list storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module spor_list_ram #(
   parameter int POOL_SLOTS = 16,
   parameter int SW         = 4
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [SW-1:0] wr_addr,
   input  wire logic [SW-1:0] wr_data,
   input  wire logic [SW-1:0] rd_addr,
   output logic      [SW-1:0] rd_data
);

   logic [SW-1:0] mem [POOL_SLOTS];
   logic [SW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/spor_marks.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spor_marks
// Active mark per slot, cleared by reset, one set/clear/read index.
// ----------------------------------------------------------------------------
module spor_marks #(
   parameter int POOL_SLOTS = 16,
   parameter int SW         = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          mark_set,
   input  wire logic          mark_clr,
   input  wire logic [SW-1:0] mark_idx,
   output logic               mark_bit
);

   logic [POOL_SLOTS-1:0] marks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         marks_ff <= '0;
      end else if (mark_set) begin
         marks_ff[mark_idx] <= 1'b1;
      end else if (mark_clr) begin
         marks_ff[mark_idx] <= 1'b0;
      end
   end

   assign mark_bit = marks_ff[mark_idx];

endmodule
`default_nettype wire

// ===== rtl/spor_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spor_seq
// Sequencer with one shared index counter and compare: scans marks, searches
// the list and compacts it one entry at a time in a read state and a write state.
// ----------------------------------------------------------------------------
module spor_seq
   import spor_pkg::*;
#(
   parameter int POOL_SLOTS = 16,
   parameter int SW         = 4,
   parameter int CW         = 5
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire req_type       req_data,
   output logic               req_stall,
   input  wire logic [CW-1:0] slots_eff,
   input  wire logic          out_free,
   output seq_out_type        seq_out,
   input  wire logic          mark_bit,
   output logic               mark_set,
   output logic               mark_clr,
   output logic      [SW-1:0] mark_idx,
   output logic               wr_en,
   output logic      [SW-1:0] wr_addr,
   output logic      [SW-1:0] wr_data,
   output logic      [SW-1:0] rd_addr,
   input  wire logic [SW-1:0] rd_data
);

   state_type     state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] tgt_ff, tgt_in;
   logic          op_ff, op_in;
   logic          rng_ff, rng_in;
   rsp_type       res_ff, res_in;

   logic          accept;
   logic [CW-1:0] idx_nx;
   logic [CW-1:0] count_dec;
   logic          scan_live;
   logic          shift_more;

   assign accept     = req_valid && !req_stall;
   assign idx_nx     = idx_ff + CW'(1);
   assign count_dec  = count_ff - CW'(1);
   assign scan_live  = idx_ff < slots_eff;
   assign shift_more = idx_nx < count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.opcode == OP_RELEASE) ? ST_REL_CHK : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_live) begin
               if (!mark_bit) begin
                  state_in = ST_DONE;
               end
            end else if (count_ff != '0) begin
               state_in = ST_OLD_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_OLD_RD:   state_in = ST_OLD_WAIT;
         ST_OLD_WAIT: state_in = ST_SHIFT_RD;
         ST_REL_CHK: begin
            state_in = (rng_ff && mark_bit) ? ST_FIND_RD : ST_DONE;
         end
         ST_FIND_RD:  state_in = ST_FIND_CMP;
         ST_FIND_CMP: begin
            state_in = (rd_data == tgt_ff) ? ST_SHIFT_RD : ST_FIND_RD;
         end
         ST_SHIFT_RD: begin
            state_in = shift_more ? ST_SHIFT_WR : ST_DONE;
         end
         ST_SHIFT_WR: state_in = ST_SHIFT_RD;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall = 1'b1;
      mark_set  = 1'b0;
      mark_clr  = 1'b0;
      mark_idx  = idx_ff[SW-1:0];
      wr_en     = 1'b0;
      wr_addr   = idx_ff[SW-1:0];
      wr_data   = rd_data;
      rd_addr   = idx_ff[SW-1:0];
      seq_out   = '{done: 1'b0, rsp: res_ff};
      idx_in    = idx_ff;
      count_in  = count_ff;
      tgt_in    = tgt_ff;
      op_in     = op_ff;
      rng_in    = rng_ff;
      res_in    = res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (accept) begin
               op_in  = req_data.opcode;
               tgt_in = SW'(req_data.slot_number);
               rng_in = 32'(req_data.slot_number) < 32'(POOL_SLOTS);
               idx_in = (req_data.opcode == OP_RELEASE) ? CW'(req_data.slot_number) : '0;
            end
         end
         ST_SCAN: begin
            if (scan_live) begin
               if (!mark_bit) begin
                  mark_set = 1'b1;
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[SW-1:0];
                  wr_data  = idx_ff[SW-1:0];
                  count_in = count_ff + CW'(1);
                  res_in   = '{ok: 1'b1, granted_slot: SLOT_WIDTH'(idx_ff), recycled: 1'b0};
               end else begin
                  idx_in = idx_nx;
               end
            end else if (count_ff == '0) begin
               res_in = '0;
            end
         end
         ST_OLD_RD: begin
            rd_addr = '0;
         end
         ST_OLD_WAIT: begin
            tgt_in = rd_data;
            idx_in = '0;
         end
         ST_REL_CHK: begin
            if (rng_ff && mark_bit) begin
               mark_clr = 1'b1;
               idx_in   = '0;
            end else begin
               res_in = '0;
            end
         end
         ST_FIND_RD: begin
            rd_addr = idx_ff[SW-1:0];
         end
         ST_FIND_CMP: begin
            if (rd_data != tgt_ff) begin
               idx_in = idx_nx;
            end
         end
         ST_SHIFT_RD: begin
            if (shift_more) begin
               rd_addr = idx_nx[SW-1:0];
            end else if (op_ff == OP_ALLOC) begin
               wr_en   = 1'b1;
               wr_addr = count_dec[SW-1:0];
               wr_data = tgt_ff;
               res_in  = '{ok: 1'b1, granted_slot: SLOT_WIDTH'(tgt_ff), recycled: 1'b1};
            end else begin
               count_in = count_dec;
               res_in   = '{ok: 1'b1, granted_slot: '0, recycled: 1'b0};
            end
         end
         ST_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[SW-1:0];
            wr_data = rd_data;
            idx_in  = idx_nx;
         end
         ST_DONE: begin
            seq_out.done = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      tgt_ff <= tgt_in;
      op_ff  <= op_in;
      rng_ff <= rng_in;
      res_ff <= res_in;
   end

endmodule
`default_nettype wire

// ===== rtl/slot_pool_oldest_recycle_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slot_pool_oldest_recycle_unit
// Slot pool: allocate grants the lowest free slot or recycles the oldest
// active one; release drops a slot from the allocation-order list.
//
//   channel   ports                         role
//   request   req_valid  req_stall req_data  in, opcode and slot_number
//   response  rsp_valid  rsp_stall rsp_data  out, ok/granted_slot/recycled
//   config    csr_write_en csr_write_data    slots_in_use, reset 16
//
// one request at a time; req_stall is high from acceptance until the result
// enters the output register. allocate scans the marks from slot 0; recycle
// reads the oldest list entry, then compacts the list; release searches the
// list, then compacts it; one index counter walks the marks and the list ram.
// synchronous reset clears the marks and the list count; no clearing pass.
// the output register lets a new request in while a response is stalled.
// ----------------------------------------------------------------------------
module slot_pool_oldest_recycle_unit
   import spor_pkg::*;
#(
   parameter int POOL_SLOTS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_WIDTH-1:0] csr_write_data
);

   localparam int SW = $clog2(POOL_SLOTS);
   localparam int CW = $clog2(POOL_SLOTS + 1);
   localparam int EW = (CW > CSR_WIDTH) ? CW : CSR_WIDTH;

   logic [CSR_WIDTH-1:0] csr_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [EW-1:0]        slots_ext;
   logic [CW-1:0]        slots_eff;
   logic                 out_free;
   seq_out_type          seq_out;

   logic                 mark_bit, mark_set, mark_clr;
   logic [SW-1:0]        mark_idx;
   logic                 wr_en;
   logic [SW-1:0]        wr_addr, wr_data, rd_addr, rd_data;

   assign slots_ext = (EW'(csr_ff) > EW'(POOL_SLOTS)) ? EW'(POOL_SLOTS) : EW'(csr_ff);
   assign slots_eff = CW'(slots_ext);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CSR_RESET;
      end else if (csr_write_en) begin
         csr_ff <= csr_write_data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (seq_out.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_out.rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   spor_seq #(
      .POOL_SLOTS (POOL_SLOTS),
      .SW         (SW),
      .CW         (CW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .slots_eff (slots_eff),
      .out_free  (out_free),
      .seq_out   (seq_out),
      .mark_bit  (mark_bit),
      .mark_set  (mark_set),
      .mark_clr  (mark_clr),
      .mark_idx  (mark_idx),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   spor_marks #(
      .POOL_SLOTS (POOL_SLOTS),
      .SW         (SW)
   ) u_marks (
      .clock    (clock),
      .reset    (reset),
      .mark_set (mark_set),
      .mark_clr (mark_clr),
      .mark_idx (mark_idx),
      .mark_bit (mark_bit)
   );

   spor_list_ram #(
      .POOL_SLOTS (POOL_SLOTS),
      .SW         (SW)
   ) u_list (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
`default_nettype wire

// ===== rtl/spor_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spor_checker
// Port-level checks of the slot pool, bound to the top level.
// ----------------------------------------------------------------------------
module spor_checker
   import spor_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   a_reset_clears_rsp : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_refused_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.ok |-> rsp_data.granted_slot == '0 && !rsp_data.recycled)
      else $error("refused request carries a grant");

   a_recycled_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.recycled |-> rsp_data.ok)
      else $error("recycled without ok");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

endmodule

bind slot_pool_oldest_recycle_unit spor_checker u_checker (.*);
`default_nettype wire

// ===== tb/slot_pool_oldest_recycle_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_pool_oldest_recycle_unit_test
// Self-checking bench for the slot pool. A behavioral copy of the pool
// (active marks plus allocation-order list) predicts every response, which
// is checked field by field as it leaves the block. Directed requests cover
// an empty pool, a full fill, recycling of the oldest slot and the extremes
// of slots_in_use; random phases then mix allocates with releases of mostly
// active slots under random request gaps and response stalls.
// ----------------------------------------------------------------------------
module slot_pool_oldest_recycle_unit_test;
   import spor_pkg::*;

   localparam int POOL_SLOTS    = 16;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int RANDOM_PHASES = 13;
   localparam int PHASE_ITEMS   = 100;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   req_type              req_data       = '0;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write_en   = 1'b0;
   logic [CSR_WIDTH-1:0] csr_write_data = '0;

   // pool state as the block should hold it
   logic [POOL_SLOTS-1:0] slot_busy   = '0;
   logic [3:0]            alloc_order[$];
   logic [CSR_WIDTH-1:0]  slots_limit = CSR_RESET;
   rsp_type               awaited_answers[$];

   int fail_count  = 0;
   int cycle_count = 0;
   int stall_left  = 0;
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;

   slot_pool_oldest_recycle_unit #(
      .POOL_SLOTS(POOL_SLOTS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type pool_answer(req_type item);
      rsp_type    answer;
      int         limit;
      int         free_slot;
      logic [3:0] oldest;
      answer    = '0;
      free_slot = -1;
      if (item.opcode == OP_ALLOC) begin
         limit = (slots_limit > POOL_SLOTS) ? POOL_SLOTS : int'(slots_limit);
         for (int i = limit - 1; i >= 0; i--)
            if (!slot_busy[i]) free_slot = i;
         if (free_slot >= 0) begin
            slot_busy[free_slot] = 1'b1;
            alloc_order.push_back(4'(free_slot));
            answer.ok           = 1'b1;
            answer.granted_slot = 4'(free_slot);
         end else if (alloc_order.size() > 0) begin
            oldest = alloc_order.pop_front();
            alloc_order.push_back(oldest);
            answer.ok           = 1'b1;
            answer.granted_slot = oldest;
            answer.recycled     = 1'b1;
         end
      end else if (slot_busy[item.slot_number]) begin
         for (int i = 0; i < alloc_order.size(); i++) begin
            if (alloc_order[i] == item.slot_number) begin
               alloc_order.delete(i);
               break;
            end
         end
         slot_busy[item.slot_number] = 1'b0;
         answer.ok = 1'b1;
      end
      return answer;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d",
               cycle_count, what, got, want);
      fail_count++;
   endtask

   task automatic send_request(logic opcode, logic [SLOT_WIDTH-1:0] slot);
      req_type item;
      item.opcode      = opcode;
      item.slot_number = slot;
      if (req_idle_on && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      awaited_answers.push_back(pool_answer(item));
   endtask

   task automatic wait_for_answers();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_answers.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_slots_in_use(logic [CSR_WIDTH-1:0] value);
      wait_for_answers();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      slots_limit = value;
      @(posedge clock);
   endtask

   // response check
   always @(posedge clock) begin : check_answers
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_answers.size() == 0) begin
            report_mismatch("response with none pending", int'(rsp_data), -1);
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_data.ok !== want.ok)
               report_mismatch("ok", int'(rsp_data.ok), int'(want.ok));
            if (rsp_data.granted_slot !== want.granted_slot)
               report_mismatch("granted_slot", int'(rsp_data.granted_slot),
                               int'(want.granted_slot));
            if (rsp_data.recycled !== want.recycled)
               report_mismatch("recycled", int'(rsp_data.recycled),
                               int'(want.recycled));
         end
      end
   end

   // response stall bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 9);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic test_empty_release();
      send_request(OP_RELEASE, 4'd15);
   endtask

   task automatic test_fill_order();
      repeat (POOL_SLOTS) send_request(OP_ALLOC, 4'($urandom_range(0, 15)));
   endtask

   task automatic test_recycle_oldest();
      send_request(OP_ALLOC, 4'd15);
      send_request(OP_RELEASE, 4'd15);
      send_request(OP_RELEASE, 4'd15);
      send_request(OP_ALLOC, 4'd0);
   endtask

   task automatic test_register_limits();
      write_slots_in_use(5'd0);
      send_request(OP_ALLOC, 4'd0);
      write_slots_in_use(5'd31);
      send_request(OP_ALLOC, 4'd0);
      write_slots_in_use(5'd2);
      send_request(OP_RELEASE, 4'd1);
      send_request(OP_ALLOC, 4'd0);
   endtask

   task automatic test_random_traffic();
      int         alloc_pct;
      logic [3:0] slot;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: write_slots_in_use(5'd16);
            1: write_slots_in_use(5'd3);
            2: write_slots_in_use(5'd0);
            3: write_slots_in_use(5'd1);
            4: write_slots_in_use(5'd31);
            5: write_slots_in_use(5'd8);
            default: write_slots_in_use(5'($urandom_range(0, 31)));
         endcase
         req_idle_on = (phase < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
         rsp_idle_on = (phase < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
         alloc_pct   = $urandom_range(30, 75);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < alloc_pct) begin
               send_request(OP_ALLOC, 4'($urandom_range(0, 15)));
            end else begin
               if (alloc_order.size() > 0 && $urandom_range(0, 9) < 7)
                  slot = alloc_order[$urandom_range(0, alloc_order.size() - 1)];
               else
                  slot = 4'($urandom_range(0, 15));
               send_request(OP_RELEASE, slot);
            end
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_release();
      test_fill_order();
      test_recycle_oldest();
      test_register_limits();
      test_random_traffic();
      wait_for_answers();
      repeat (20) @(posedge clock);
      if (awaited_answers.size() != 0)
         report_mismatch("responses missing", awaited_answers.size(), 0);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
